// ----- rtl/core/assert_macros.svh -----
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PWLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwli: same-cycle check failed");

// next-cycle implication
`define PWLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwli: next-cycle check failed");

`endif

// ----- rtl/core/pwli_pkg.sv -----
// types and constants of the piecewise linear interpolator
`default_nettype none

package pwli_pkg;

    localparam int PWLI_MAX_POINTS = 256;
    localparam int PWLI_MIN_POINTS = 2;
    localparam int PNT_W           = 9;
    localparam int FRAC_W          = 16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic               action;
        logic        [7:0]  load_index;
        logic signed [31:0] load_x;
        logic signed [31:0] load_f;
        logic signed [31:0] query_x;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               table_error;
    } t_out_word;

endpackage

`default_nettype wire

// ----- rtl/core/pwli_div.sv -----
// restoring divider for the blend fraction, one quotient bit per cycle
`default_nettype none

module pwli_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [pwli_pkg::FRAC_W-1:0] o_quot
);
    import pwli_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [FRAC_W-1:0] r_quot;

    logic [32:0] w_rem2;
    logic        w_ge;
    logic [31:0] w_rem_n;

    // remainder stays below the divisor, so it always fits 32 bits
    always_comb begin
        w_rem2  = {r_rem, 1'b0};
        w_ge    = (w_rem2 >= {1'b0, r_den});
        w_rem_n = w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_num;
                r_den <= i_den;
                r_cnt <= CNT_W'(FRAC_W);
            end else if (r_cnt != '0) begin
                r_rem  <= w_rem_n;
                r_quot <= {r_quot[FRAC_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- rtl/core/piecewise_linear_interpolator.sv -----
// piecewise linear interpolator: breakpoint memories, search sequencer and blend datapath
//
// Input channel (i_in_valid / o_in_stall) carries one word: a load writes one
// breakpoint into the x and f memories with no stall; a query searches the
// table and yields one result word on the output channel (o_out_valid / i_out_stall).
// One word is worked on at a time; o_in_stall is high from a query's acceptance
// until its result has moved into the output register.
// A query runs binary search steps of one memory read and one compare each,
// ceil(log2(n+1)) steps for n points, then the final probe, the fetch of the two
// neighbours, the serial division (16 steps), the multiply and the saturating add.
// Queries outside the table skip the divider; with fewer than two points a query
// yields an error result without a search. The single read port of each memory
// and the serial divider set the length of a query.
// The output register holds a finished result while i_out_stall is high; the
// next word is still accepted, and its result waits in the sequencer.
// The user must write point_count through the cfg channel (always ready) only
// while idle; the block itself does not enforce this. Reset clears the control
// state and point_count; memory contents are undefined until written.
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pwli_pkg::PWLI_MAX_POINTS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [pwli_pkg::PNT_W-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pwli_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pwli_pkg::t_out_word       o_out_word
);
    import pwli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > PNT_W) ? CW : PNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_CMP, S_FETCH, S_EDGE, S_HI, S_LO,
        S_PREP, S_DIV, S_MUL, S_SUM, S_OUT
    } t_state;

    // breakpoint memories
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_f [MAX_POINTS];
    logic signed [31:0] r_x_q;
    logic signed [31:0] r_f_q;

    t_state              r_state;
    logic [PNT_W-1:0]    r_point_count;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_first;
    logic [CW-1:0]       r_count;
    logic signed [31:0]  r_q;
    logic signed [31:0]  r_x1;
    logic signed [31:0]  r_f1;
    logic signed [31:0]  r_f0;
    logic signed [32:0]  r_d;
    logic signed [32:0]  r_num;
    logic signed [32:0]  r_df;
    logic [FRAC_W:0]     r_t;
    logic signed [50:0]  r_prod;
    logic                r_div_start;
    t_out_word           r_res;
    t_out_word           r_out;
    logic                r_out_vld;

    logic                w_in_acc;
    logic                w_wr;
    logic [NW-1:0]       w_pc_ext;
    logic [CW-1:0]       w_n;
    logic [CW-1:0]       w_step;
    logic [CW-1:0]       w_probe;
    logic [CW-1:0]       w_last;
    logic [CW-1:0]       w_first_m1;
    logic [AW-1:0]       w_rd_addr;
    logic signed [17:0]  w_t_s;
    logic signed [34:0]  w_sum;
    logic signed [31:0]  w_sat;
    logic                w_div_done;
    logic [FRAC_W-1:0]   w_quot;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_wr     = w_in_acc && (i_in_word.action == ACT_LOAD)
                      && (32'(i_in_word.load_index) < 32'(MAX_POINTS));

    always_comb begin
        w_pc_ext   = NW'(r_point_count);
        w_n        = (w_pc_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(w_pc_ext);
        w_step     = r_count >> 1;
        w_probe    = r_first + w_step;
        w_last     = r_n - CW'(1);
        w_first_m1 = r_first - CW'(1);
        w_t_s      = $signed({1'b0, r_t});
        w_sum      = {{3{r_f0[31]}}, r_f0} + r_prod[50:16];
        if (w_sum > 35'sd2147483647) begin
            w_sat = 32'sh7fffffff;
        end else if (w_sum < -35'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    // read address follows the sequencer state
    always_comb begin
        unique case (r_state)
            S_SRCH:  w_rd_addr = w_probe[AW-1:0];
            S_FETCH: begin
                if (r_first == '0) begin
                    w_rd_addr = '0;
                end else if (r_first >= r_n) begin
                    w_rd_addr = w_last[AW-1:0];
                end else begin
                    w_rd_addr = r_first[AW-1:0];
                end
            end
            S_HI:    w_rd_addr = w_first_m1[AW-1:0];
            default: w_rd_addr = '0;
        endcase
    end

    // loads happen only while idle, so reads never overlap a write
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_x[AW'(i_in_word.load_index)] <= i_in_word.load_x;
            mem_f[AW'(i_in_word.load_index)] <= i_in_word.load_f;
        end
        r_x_q <= mem_x[w_rd_addr];
        r_f_q <= mem_f[w_rd_addr];
    end

    pwli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num[31:0]),
        .i_den   (r_d[31:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_out_vld     <= 1'b0;
            r_div_start   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_word.action == ACT_QUERY)) begin
                        r_n     <= w_n;
                        r_first <= '0;
                        r_count <= w_n;
                        r_q     <= i_in_word.query_x;
                        if (32'(w_n) < 32'(PWLI_MIN_POINTS)) begin
                            r_res.interp_value <= '0;
                            r_res.table_error  <= 1'b1;
                            r_state            <= S_OUT;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    r_state <= (r_count == '0) ? S_FETCH : S_CMP;
                end
                S_CMP: begin
                    if (r_x_q < r_q) begin
                        r_first <= w_probe + CW'(1);
                        r_count <= r_count - w_step - CW'(1);
                    end else begin
                        r_count <= w_step;
                    end
                    r_state <= S_SRCH;
                end
                S_FETCH: begin
                    // below or above the table answers with an end point
                    if ((r_first == '0) || (r_first >= r_n)) begin
                        r_state <= S_EDGE;
                    end else begin
                        r_state <= S_HI;
                    end
                end
                S_EDGE: begin
                    r_res.interp_value <= r_f_q;
                    r_res.table_error  <= 1'b0;
                    r_state            <= S_OUT;
                end
                S_HI: begin
                    r_x1    <= r_x_q;
                    r_f1    <= r_f_q;
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_f0    <= r_f_q;
                    r_d     <= {r_x1[31], r_x1} - {r_x_q[31], r_x_q};
                    r_num   <= {r_q[31], r_q} - {r_x_q[31], r_x_q};
                    r_df    <= {r_f1[31], r_f1} - {r_f_q[31], r_f_q};
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    priority if (r_d == '0) begin
                        r_res.interp_value <= r_f0;
                        r_res.table_error  <= 1'b0;
                        r_state            <= S_OUT;
                    end else if (r_d[32] || r_num[32] || (r_num == '0)) begin
                        r_t     <= '0;
                        r_state <= S_MUL;
                    end else if (r_num >= r_d) begin
                        r_t     <= (FRAC_W+1)'(1) << FRAC_W;
                        r_state <= S_MUL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= {1'b0, w_quot};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_t_s * r_df;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_res.interp_value <= w_sat;
                    r_res.table_error  <= 1'b0;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/pwli_chk.sv -----
// port-level checker for the piecewise linear interpolator, with its bind
`default_nettype none

`include "assert_macros.svh"

module pwli_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_stall,
    input wire pwli_pkg::t_in_word  i_in_word,
    input wire logic                i_out_valid,
    input wire logic                i_out_stall,
    input wire pwli_pkg::t_out_word i_out_word
);
    import pwli_pkg::*;

    logic w_load_acc;
    logic w_query_acc;
    logic w_out_held;
    logic w_out_err;

    assign w_load_acc  = i_in_valid && !i_in_stall && (i_in_word.action == ACT_LOAD);
    assign w_query_acc = i_in_valid && !i_in_stall && (i_in_word.action == ACT_QUERY);
    assign w_out_held  = i_out_valid && i_out_stall;
    assign w_out_err   = i_out_valid && i_out_word.table_error;

    // a held result word stays put
    `PWLI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_held, i_out_valid && $stable(i_out_word))
    // an error result carries a zero value
    `PWLI_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, w_out_err, i_out_word.interp_value == 32'sd0)
    // an accepted query makes the block stall its input
    `PWLI_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, w_query_acc, i_in_stall)
    // a load completes in its own cycle
    `PWLI_ASSERT_NXT(a_load_free, i_clk, i_rst_n, w_load_acc, !i_in_stall)

endmodule

bind piecewise_linear_interpolator pwli_chk u_pwli_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);

`default_nettype wire
